>>> rtl/ctt_pkg.sv
// Shared types, codes and field layouts for the command completion tracker.
package ctt_pkg;

  // Field widths
  localparam int unsigned ID_BITS   = 16;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CODE_BITS = 8;
  localparam int unsigned CMD_BITS  = 2;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Packed stream widths (rounded up to whole bytes)
  localparam int unsigned IN_DATA_BITS  = 80;
  localparam int unsigned OUT_DATA_BITS = 56;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FORWARD = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_ROTATE  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD_CODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROTATE_CODE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE_TIMEOUT = 2'd3;

  // Register reset values
  localparam logic [CODE_BITS-1:0] FORWARD_CODE_RST    = 8'd0;
  localparam logic [CODE_BITS-1:0] ROTATE_CODE_RST     = 8'd1;
  localparam logic [TIME_BITS-1:0] START_TIMEOUT_RST   = 32'd3000;
  localparam logic [TIME_BITS-1:0] SILENCE_TIMEOUT_RST = 32'd5000;

  // Status codes from the controller
  localparam logic [CODE_BITS-1:0] EXEC_COMPLETE = 8'd3;
  localparam logic [CODE_BITS-1:0] FAIL_NONE     = 8'd0;

  // Configuration set
  typedef struct packed {
    logic [CODE_BITS-1:0] forward_code;
    logic [CODE_BITS-1:0] rotate_code;
    logic [TIME_BITS-1:0] start_timeout;
    logic [TIME_BITS-1:0] silence_timeout;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [TIME_BITS-1:0] now_time;
    logic                 status_valid;
    logic [ID_BITS-1:0]   status_id;
    logic [CODE_BITS-1:0] status_primitive;
    logic [CODE_BITS-1:0] status_exec;
    logic [CODE_BITS-1:0] status_failure;
  } item_t;

  // Tracking state
  typedef struct packed {
    logic                 waiting;
    logic                 running;
    logic                 complete;
    logic                 success;
    logic                 timeout;
    logic                 expect_rotate;
    logic [TIME_BITS-1:0] sent_at;
    logic [ID_BITS-1:0]   baseline_id;
    logic [ID_BITS-1:0]   tracked;
    logic [TIME_BITS-1:0] start_seen_at;
    logic [TIME_BITS-1:0] last_status_at;
  } track_t;

endpackage

>>> rtl/ctt_cfg.sv
// Configuration register bank of the command completion tracker.
module ctt_cfg
  import ctt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]    cfg_data,
  output cfg_t                    cfg
);

  // Register writes, one per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_code    <= FORWARD_CODE_RST;
      cfg.rotate_code     <= ROTATE_CODE_RST;
      cfg.start_timeout   <= START_TIMEOUT_RST;
      cfg.silence_timeout <= SILENCE_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORWARD_CODE:    cfg.forward_code    <= cfg_data[CODE_BITS-1:0];
        REG_ROTATE_CODE:     cfg.rotate_code     <= cfg_data[CODE_BITS-1:0];
        REG_START_TIMEOUT:   cfg.start_timeout   <= cfg_data;
        REG_SILENCE_TIMEOUT: cfg.silence_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ctt_in_stage.sv
// Input register stage: unpacks and holds one input transaction.
module ctt_in_stage
  import ctt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_BITS-1:0] s_tdata,
  input  logic [CMD_BITS-1:0]     s_tuser,
  input  logic                    advance,
  output logic                    item_valid,
  output item_t                   item
);

  assign s_tready = !item_valid || advance;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command          <= s_tuser;
      item.now_time         <= s_tdata[31:0];
      item.status_valid     <= s_tdata[32];
      item.status_id        <= s_tdata[48:33];
      item.status_primitive <= s_tdata[56:49];
      item.status_exec      <= s_tdata[64:57];
      item.status_failure   <= s_tdata[72:65];
    end
  end

endmodule

>>> rtl/ctt_core.sv
// Tracking state update and result register.
module ctt_core
  import ctt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     item_valid,
  input  item_t                    item,
  output logic                     advance,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  track_t               st;
  track_t               st_next;
  logic [CODE_BITS-1:0] want;
  logic                 prim_ok;
  logic [TIME_BITS-1:0] ref_time;
  logic [TIME_BITS-1:0] limit;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  logic                 is_send;

  assign advance = item_valid && (!m_tvalid || m_tready);

  // Elapsed-time check: start timeout before tracking, silence timeout after
  assign ref_time = (st.tracked == '0) ? st.sent_at : st.last_status_at;
  assign limit    = (st.tracked == '0) ? cfg.start_timeout : cfg.silence_timeout;
  assign elapsed  = item.now_time - ref_time;
  assign expired  = elapsed >= limit;

  assign want    = st.expect_rotate ? cfg.rotate_code : cfg.forward_code;
  assign prim_ok = item.status_valid && (item.status_id != '0)
                   && (item.status_primitive == want);
  assign is_send = (item.command == CMD_FORWARD) || (item.command == CMD_ROTATE);

  // Next tracking state for the held transaction
  always_comb begin
    st_next = st;
    if (is_send) begin
      st_next               = '0;
      st_next.waiting       = 1'b1;
      st_next.expect_rotate = (item.command == CMD_ROTATE);
      st_next.sent_at       = item.now_time;
      st_next.baseline_id   = item.status_valid ? item.status_id : '0;
    end else if (st.waiting || st.running) begin
      if ((st.tracked == '0) ? (prim_ok && item.status_id != st.baseline_id)
                             : (prim_ok && item.status_id == st.tracked)) begin
        // Matching status: start, keep alive or complete
        if (st.tracked == '0) begin
          st_next.tracked       = item.status_id;
          st_next.start_seen_at = item.now_time;
        end
        st_next.last_status_at = item.now_time;
        st_next.waiting        = 1'b0;
        if (item.status_exec == EXEC_COMPLETE) begin
          st_next.running  = 1'b0;
          st_next.complete = 1'b1;
          st_next.success  = (item.status_failure == FAIL_NONE);
          st_next.timeout  = 1'b0;
        end else begin
          st_next.running = 1'b1;
        end
      end else if (expired) begin
        st_next.waiting  = 1'b0;
        st_next.running  = 1'b0;
        st_next.complete = 1'b1;
        st_next.success  = 1'b0;
        st_next.timeout  = 1'b1;
      end else if (st.tracked != '0) begin
        st_next.waiting = 1'b0;
        st_next.running = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'b000, st_next.start_seen_at, st_next.tracked, st_next.timeout,
                  st_next.complete && st_next.success, st_next.complete,
                  st_next.running, st_next.waiting || st_next.running};
    end
  end

endmodule

>>> rtl/command_completion_tracker.sv
// Top level of the command completion tracker.
//
// Follows one motion command sent to a motion controller. Input transactions
// arrive on the s_ stream: s_tuser carries the command (tick, drive forward
// sent, rotate sent) and s_tdata the time and the controller status. Every
// input transaction yields exactly one result transaction on the m_ stream
// with the busy/running/done/success/timeout flags, the tracked id and the
// time the start was seen.
// Registers (primitive codes and the two timeouts) are written through the
// cfg_ channel, which is always ready; write them only while the block holds
// no transaction.
// Between input and result lie the input register, then the state update and
// result register. Throughput is one transaction per cycle while m_tready is
// high, set by the state update loop (one subtract and compare).
// When m_tready is low the result register holds and the input register
// still takes one more transaction, if it is empty, before s_tready drops.
// Reset clears all tracking state and reloads the register defaults.
module command_completion_tracker
  import ctt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // now_time[31:0], status_valid[32], status_id[48:33],
  // status_primitive[56:49], status_exec[64:57], status_failure[72:65]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // command[1:0]
  input  logic [CMD_BITS-1:0]      s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // busy_res[0], running_now[1], done_res[2], succeeded[3],
  // timed_out_flag[4], tracked_id[20:5], start_time[52:21]
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [TIME_BITS-1:0]     cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;

  assign cfg_ready = 1'b1;

  ctt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ctt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> rtl/ctt_checker.sv
// Port-level assertions for the command completion tracker, bound to the top.
module ctt_checker
  import ctt_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A finished command is never busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
    else $error("done while busy");

  // Success excludes timeout and needs done
  a_success: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2] && !m_tdata[4])
    else $error("success flag inconsistent");

  // Running means tracking a nonzero id
  a_running_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0] && (m_tdata[20:5] != '0))
    else $error("running without a tracked id");

endmodule

bind command_completion_tracker ctt_checker u_ctt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
